[rtl/comrf_pkg.sv]
// shared types and constants of the clock offset min round trip filter
// no dependencies
package comrf_pkg;

  localparam int unsigned TimeW  = 64;
  localparam int unsigned EntryW = 2 * TimeW;

  localparam logic [TimeW-1:0] ALL_ONES  = {TimeW{1'b1}};
  localparam logic [TimeW-1:0] POS_LIMIT = {1'b0, {(TimeW-1){1'b1}}};
  localparam logic [TimeW-1:0] NEG_LIMIT = {1'b1, {(TimeW-1){1'b0}}};

  typedef struct packed {
    logic [TimeW-1:0] offset;
    logic [TimeW-1:0] round_trip;
  } calc_result_t;

endpackage

[rtl/comrf_if.sv]
// valid/ready channel interfaces for samples and results
// depends on nothing

interface comrf_sample_if;
  logic        valid;
  logic        ready;
  logic [63:0] client_send_time;
  logic [63:0] server_recv_time;
  logic [63:0] server_send_time;
  logic [63:0] client_recv_time;

  modport source (output valid, client_send_time, server_recv_time, server_send_time,
                  client_recv_time, input ready);
  modport sink (input valid, client_send_time, server_recv_time, server_send_time,
                client_recv_time, output ready);
endinterface

interface comrf_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] best_offset;
  logic        [63:0] best_round_trip;
  logic               best_valid;

  modport source (output valid, best_offset, best_round_trip, best_valid, input ready);
  modport sink (input valid, best_offset, best_round_trip, best_valid, output ready);
endinterface

[rtl/comrf_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module comrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/comrf_sample_calc.sv]
// three-stage pipeline computing round trip and halved, saturated offset
// depends on comrf_pkg
module comrf_sample_calc (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [63:0]            t1,
  input  logic [63:0]            t2,
  input  logic [63:0]            t3,
  input  logic [63:0]            t4,
  output logic                   done,
  output comrf_pkg::calc_result_t res
);
  import comrf_pkg::*;

  logic        s1_valid;
  logic        s2_valid;
  logic [64:0] p_sum;
  logic [64:0] n_sum;
  logic [64:0] d41;
  logic [64:0] d32;
  logic [65:0] diff;
  logic [63:0] rtt2;
  logic        neg_rtt;
  logic [65:0] sum_adj;
  logic [64:0] q;

  assign neg_rtt = d41[64] | d32[64] | (d41[63:0] < d32[63:0]);
  assign sum_adj = diff + {65'd0, diff[65]};
  assign q       = sum_adj[65:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
    p_sum <= {1'b0, t2} + {1'b0, t3};
    n_sum <= {1'b0, t1} + {1'b0, t4};
    d41   <= {1'b0, t4} - {1'b0, t1};
    d32   <= {1'b0, t3} - {1'b0, t2};
    diff  <= {1'b0, p_sum} - {1'b0, n_sum};
    rtt2  <= neg_rtt ? ALL_ONES : (d41[63:0] - d32[63:0]);
    res.round_trip <= rtt2;
    if (q[64] != q[63]) begin
      res.offset <= q[64] ? NEG_LIMIT : POS_LIMIT;
    end else begin
      res.offset <= q[63:0];
    end
  end

endmodule

[rtl/clock_offset_min_rtt_filter.sv]
// minimum round trip clock offset filter, top level
// a result transaction follows every accepted sample; the best is rescanned when a worse sample overwrites its slot
// a new sample is taken only in the idle state, once the result of the previous one has been issued
// the rescan reads one ring entry per cycle through the single ram read port
// synchronous reset clears valid bits, write pointer and held best; ram needs no clearing
// depends on comrf_pkg, comrf_if, comrf_ram, comrf_sample_calc
module clock_offset_min_rtt_filter #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  comrf_sample_if.sink   sample,
  comrf_result_if.source result
);
  import comrf_pkg::*;

  localparam int unsigned IdxW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t          state;
  logic [RING_DEPTH-1:0] entry_valid;
  logic [IdxW-1:0] wr_ptr;
  logic [63:0]     held_rtt;
  logic [63:0]     held_off;
  logic            have_best;
  logic            replacing;
  logic            accept_d;
  logic [IdxW-1:0] scan_addr;
  logic            scan_rd_valid;
  logic [IdxW-1:0] scan_rd_idx;
  logic [63:0]     cand_rtt;
  logic [63:0]     cand_off;
  logic            found;

  logic            accept;
  logic            calc_done;
  calc_result_t    calc_res;
  logic            ram_wr;
  logic [IdxW-1:0] ram_rd_addr;
  logic [EntryW-1:0] ram_rd_data;
  calc_result_t    rd_entry;
  logic            out_free;

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE);
  assign ram_wr       = (state == ST_CALC) && calc_done;
  assign ram_rd_addr  = (state == ST_SCAN) ? scan_addr : wr_ptr;
  assign rd_entry     = calc_result_t'(ram_rd_data);
  assign out_free     = !result.valid || result.ready;

  comrf_sample_calc u_calc (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .t1    (sample.client_send_time),
    .t2    (sample.server_recv_time),
    .t3    (sample.server_send_time),
    .t4    (sample.client_recv_time),
    .done  (calc_done),
    .res   (calc_res)
  );

  comrf_ram #(
    .Width (EntryW),
    .Depth (RING_DEPTH),
    .AddrW (IdxW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (wr_ptr),
    .wr_data (calc_res),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_valid   <= '0;
      wr_ptr        <= '0;
      held_rtt      <= '0;
      held_off      <= '0;
      have_best     <= 1'b0;
      accept_d      <= 1'b0;
      scan_rd_valid <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      accept_d      <= accept;
      scan_rd_valid <= (state == ST_SCAN);
      if (result.valid && result.ready && (state != ST_DONE)) begin
        result.valid <= 1'b0;
      end
      // old slot contents arrive from the registered ram read in the cycle after the transaction
      if (accept_d) begin
        replacing <= have_best && entry_valid[wr_ptr] &&
                     (rd_entry.round_trip == held_rtt) && (rd_entry.offset == held_off);
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (calc_done) begin
            entry_valid[wr_ptr] <= 1'b1;
            wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
            if (!have_best || (calc_res.round_trip < held_rtt)) begin
              held_rtt  <= calc_res.round_trip;
              held_off  <= calc_res.offset;
              have_best <= 1'b1;
              state     <= ST_DONE;
            end else if (replacing) begin
              scan_addr <= '0;
              cand_rtt  <= ALL_ONES;
              cand_off  <= '0;
              found     <= 1'b0;
              state     <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          scan_rd_idx   <= scan_addr;
          if (scan_addr == LastIdx) begin
            state <= ST_DRAIN;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!scan_rd_valid) begin
            have_best <= found;
            held_rtt  <= found ? cand_rtt : '0;
            held_off  <= found ? cand_off : '0;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            result.valid           <= 1'b1;
            result.best_offset     <= held_off;
            result.best_round_trip <= held_rtt;
            result.best_valid      <= have_best;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // compare returned ring entries during the rescan
      if (scan_rd_valid && entry_valid[scan_rd_idx] && (rd_entry.round_trip < cand_rtt)) begin
        cand_rtt <= rd_entry.round_trip;
        cand_off <= rd_entry.offset;
        found    <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_best_zero: assert property (@(posedge clk) disable iff (rst)
    !have_best |-> (held_rtt == '0 && held_off == '0))
    else $error("held values not cleared without a best sample");

  a_calc_in_calc: assert property (@(posedge clk) disable iff (rst)
    calc_done |-> state == ST_CALC)
    else $error("calc result arrived outside calc state");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == ST_DONE))
    else $error("result transaction raised outside done state");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    wr_ptr <= LastIdx)
    else $error("write pointer out of ring range");
`endif

endmodule

[test/tb_clock_offset_min_rtt_filter.sv]
// testbench for the minimum round trip clock offset filter: timestamp exchanges in, best sample out
// tracks the ring and the held best on its own and checks every result transaction in order
// depends on comrf_pkg, comrf_if and clock_offset_min_rtt_filter
module tb_clock_offset_min_rtt_filter;
  import comrf_pkg::*;

  localparam int unsigned RING_DEPTH = 8;
  localparam int unsigned RANDOM_EXCHANGES = 750;

  typedef struct {
    logic [63:0] client_send;
    logic [63:0] server_recv;
    logic [63:0] server_send;
    logic [63:0] client_recv;
  } exchange_t;

  typedef struct {
    logic signed [63:0] offset;
    logic [63:0]        round_trip;
    logic               valid;
  } best_report_t;

  class best_sample_tracker;
    bit                 slot_valid[RING_DEPTH];
    logic signed [63:0] slot_offset[RING_DEPTH];
    logic [63:0]        slot_round_trip[RING_DEPTH];
    int unsigned        write_slot;
    logic signed [63:0] best_offset;
    logic [63:0]        best_round_trip;
    bit                 best_held;
    best_report_t       expected_best[$];
    int                 mismatches;

    function new();
      for (int i = 0; i < RING_DEPTH; i++) begin
        slot_valid[i] = 0;
        slot_offset[i] = '0;
        slot_round_trip[i] = '0;
      end
      write_slot = 0;
      best_offset = '0;
      best_round_trip = '0;
      best_held = 0;
      mismatches = 0;
    endfunction

    function logic [63:0] round_trip_of(exchange_t x);
      logic [63:0] outbound_span;
      logic [63:0] server_span;
      outbound_span = x.client_recv - x.client_send;
      server_span = x.server_send - x.server_recv;
      if (x.client_recv >= x.client_send && x.server_send >= x.server_recv &&
          outbound_span >= server_span)
        return outbound_span - server_span;
      return ALL_ONES;
    endfunction

    function logic signed [63:0] offset_of(exchange_t x);
      logic signed [65:0] diff_sum;
      logic signed [65:0] halved;
      diff_sum = $signed({2'b00, x.server_recv}) + $signed({2'b00, x.server_send})
               - $signed({2'b00, x.client_send}) - $signed({2'b00, x.client_recv});
      halved = diff_sum / 66'sd2;
      if (halved > $signed({2'b00, POS_LIMIT}))
        return POS_LIMIT;
      if (halved < $signed({2'b11, NEG_LIMIT}))
        return NEG_LIMIT;
      return halved[63:0];
    endfunction

    function void note_sample(exchange_t x);
      logic [63:0]        rtt;
      logic signed [63:0] off;
      int unsigned        slot;
      bit                 replacing_best;
      logic [63:0]        cand_rtt;
      logic signed [63:0] cand_off;
      bit                 found;
      best_report_t       rep;
      rtt = round_trip_of(x);
      off = offset_of(x);
      slot = write_slot;
      replacing_best = best_held && slot_valid[slot] &&
                       slot_round_trip[slot] == best_round_trip &&
                       slot_offset[slot] == best_offset;
      slot_valid[slot] = 1;
      slot_offset[slot] = off;
      slot_round_trip[slot] = rtt;
      write_slot = (slot + 1) % RING_DEPTH;
      if (!best_held || rtt < best_round_trip) begin
        best_round_trip = rtt;
        best_offset = off;
        best_held = 1;
      end else if (replacing_best) begin
        cand_rtt = ALL_ONES;
        cand_off = '0;
        found = 0;
        for (int i = 0; i < RING_DEPTH; i++) begin
          if (slot_valid[i] && slot_round_trip[i] < cand_rtt) begin
            cand_rtt = slot_round_trip[i];
            cand_off = slot_offset[i];
            found = 1;
          end
        end
        best_held = found;
        best_round_trip = found ? cand_rtt : '0;
        best_offset = found ? cand_off : '0;
      end
      rep.offset = best_held ? best_offset : '0;
      rep.round_trip = best_held ? best_round_trip : '0;
      rep.valid = best_held;
      expected_best.push_back(rep);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_best(logic signed [63:0] offset, logic [63:0] round_trip, logic valid);
      best_report_t exp_rep;
      if (expected_best.size() == 0) begin
        report_mismatch("result transaction with no sample pending");
        return;
      end
      exp_rep = expected_best[0];
      expected_best.delete(0);
      if (offset !== exp_rep.offset)
        report_mismatch($sformatf("best_offset %0d, expected %0d", offset, exp_rep.offset));
      if (round_trip !== exp_rep.round_trip)
        report_mismatch($sformatf("best_round_trip %h, expected %h", round_trip,
                                  exp_rep.round_trip));
      if (valid !== exp_rep.valid)
        report_mismatch($sformatf("best_valid %b, expected %b", valid, exp_rep.valid));
    endtask
  endclass

  logic clk;
  logic rst;

  comrf_sample_if sample_ch();
  comrf_result_if result_ch();

  best_sample_tracker tracker;
  exchange_t          last_exchange;

  clock_offset_min_rtt_filter #(
    .RING_DEPTH(RING_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function logic [63:0] random_time();
    return {$urandom, $urandom};
  endfunction

  function exchange_t make_exchange();
    exchange_t   x;
    logic [63:0] skew;
    logic [63:0] tmp;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind >= 70 && kind < 80) begin
      return last_exchange;
    end
    if (kind >= 80 && kind < 90) begin
      x.client_send = random_time();
      x.server_recv = random_time();
      x.server_send = random_time();
      x.client_recv = random_time();
      return x;
    end
    x.client_send = ($urandom_range(0, 3) == 0) ? random_time() : {32'h0, $urandom};
    if ($urandom_range(0, 3) == 0)
      skew = random_time();
    else
      skew = {32'h0, $urandom_range(0, 2000)} - 64'd1000;
    x.server_recv = x.client_send + skew + 64'($urandom_range(0, 40));
    x.server_send = x.server_recv + 64'($urandom_range(0, 20));
    x.client_recv = x.server_send - skew + 64'($urandom_range(0, 40));
    if (kind >= 90) begin
      if ($urandom_range(0, 1) == 0) begin
        tmp = x.client_send;
        x.client_send = x.client_recv;
        x.client_recv = tmp;
      end else begin
        tmp = x.server_recv;
        x.server_recv = x.server_send;
        x.server_send = tmp;
      end
    end
    return x;
  endfunction

  task send_exchange(exchange_t x);
    sample_ch.valid <= 1'b1;
    sample_ch.client_send_time <= x.client_send;
    sample_ch.server_recv_time <= x.server_recv;
    sample_ch.server_send_time <= x.server_send;
    sample_ch.client_recv_time <= x.client_recv;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    tracker.note_sample(x);
    last_exchange = x;
  endtask

  initial begin
    int unsigned mode;
    int unsigned run_left;
    int unsigned phase;
    result_ch.ready <= 1'b0;
    run_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        mode = $urandom_range(0, 3);
        run_left = $urandom_range(20, 120);
      end
      run_left--;
      phase++;
      case (mode)
        0: begin
          result_ch.ready <= 1'b1;
        end
        1: begin
          result_ch.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          result_ch.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          result_ch.ready <= ((phase % 7) < 4);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.check_best(result_ch.best_offset, result_ch.best_round_trip,
                         result_ch.best_valid);
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    tracker = new();
    last_exchange = '{64'd0, 64'd0, 64'd0, 64'd0};
    rst <= 1'b1;
    sample_ch.valid <= 1'b0;
    sample_ch.client_send_time <= '0;
    sample_ch.server_recv_time <= '0;
    sample_ch.server_send_time <= '0;
    sample_ch.client_recv_time <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // identical invalid samples fill the ring, the ninth evicts the only best
    for (int i = 0; i < RING_DEPTH + 1; i++)
      send_exchange('{64'd100, 64'd50, 64'd60, 64'd90});
    send_exchange('{64'd0, 64'd0, 64'd0, 64'd0});
    send_exchange('{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES});
    send_exchange('{64'd0, 64'd10, 64'd5, 64'd100});
    send_exchange('{64'd0, 64'd0, 64'd50, 64'd20});
    send_exchange('{64'd0, ALL_ONES, ALL_ONES, 64'd0});
    send_exchange('{ALL_ONES, 64'd0, 64'd0, ALL_ONES});
    send_exchange('{64'd0, 64'd0, 64'd0, 64'd1});
    send_exchange('{64'd0, 64'd3, 64'd3, 64'd3});
    // overwrites the slot of the best, rescan finds an equal survivor
    send_exchange('{64'd0, 64'd0, 64'd0, 64'd3});
    send_exchange('{ALL_ONES - 64'd10, ALL_ONES - 64'd5, ALL_ONES - 64'd3, ALL_ONES});
    send_exchange('{64'd5, 64'd3, 64'd4, 64'd9});

    sent = 0;
    while (sent < RANDOM_EXCHANGES) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_EXCHANGES; k++) begin
        send_exchange(make_exchange());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        sample_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    sample_ch.valid <= 1'b0;

    while (tracker.expected_best.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/comrf_pkg.sv
rtl/comrf_if.sv
rtl/comrf_ram.sv
rtl/comrf_sample_calc.sv
rtl/clock_offset_min_rtt_filter.sv
test/tb_clock_offset_min_rtt_filter.sv
